@@ hw/rtl/avt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared types, register indexes, mode and axis codes, and the saturation
// helper used by the vertex transform block.
// ----------------------------------------------------------------------------
package avt_pkg;

   localparam int AVT_FRAC_BITS = 16;
   localparam int NUM_AXES      = 3;

   localparam int COORD_W  = 32;
   localparam int OFFSET_W = COORD_W + 1;
   localparam int SINE_W   = 18;
   localparam int SUM_W    = 67;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      MODE_TRANSLATE = 2'd0,
      MODE_SCALE     = 2'd1,
      MODE_ROTATE    = 2'd2,
      MODE_RESERVED  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE     = 3'd0,
      CSR_AXIS     = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3,
      CSR_CENTER_Z = 3'd4,
      CSR_COEFF    = 3'd5,
      CSR_SINE     = 3'd6
   } csr_index_type;

   localparam axis_type LANE_AXIS [NUM_AXES] = '{AXIS_X, AXIS_Y, AXIS_Z};

   typedef struct packed {
      mode_type                   mode;
      axis_type                   axis;
      logic signed [COORD_W-1:0]  center_x;
      logic signed [COORD_W-1:0]  center_y;
      logic signed [COORD_W-1:0]  center_z;
      logic signed [COORD_W-1:0]  coeff_main;
      logic signed [SINE_W-1:0]   coeff_sine;
   } cfg_type;

   // Clamp a wide signed sum to the coordinate range.
   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [SUM_W-1:0] value
   );
      logic [SUM_W-COORD_W:0] head_bits;
      head_bits = value[SUM_W-1:COORD_W-1];
      if ((&head_bits) || (~|head_bits)) begin
         return value[COORD_W-1:0];
      end else if (value[SUM_W-1]) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/avt_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex transform channels
// Valid/ready channels for vertices in, transformed vertices out, and
// register writes.
// ----------------------------------------------------------------------------
interface avt_req_if;
   import avt_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] in_x;
   logic signed [COORD_W-1:0] in_y;
   logic signed [COORD_W-1:0] in_z;

   modport source (output valid, output in_x, output in_y, output in_z, input ready);
   modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface avt_rsp_if;
   import avt_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] out_x;
   logic signed [COORD_W-1:0] out_y;
   logic signed [COORD_W-1:0] out_z;

   modport source (output valid, output out_x, output out_y, output out_z, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

interface avt_csr_if;
   import avt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/avt_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex transform registers
// Holds mode, axis, centre and coefficient registers written over the
// register channel.
// ----------------------------------------------------------------------------
module avt_regs #(
   parameter int FRAC_BITS = avt_pkg::AVT_FRAC_BITS
) (
   input  wire logic      clock,
   input  wire logic      reset,
   avt_csr_if.sink        csr,
   output avt_pkg::cfg_type cfg
);
   import avt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_MODE:     cfg_in.mode       = mode_type'(csr.data[1:0]);
            CSR_AXIS:     cfg_in.axis       = axis_type'(csr.data[1:0]);
            CSR_CENTER_X: cfg_in.center_x   = csr.data;
            CSR_CENTER_Y: cfg_in.center_y   = csr.data;
            CSR_CENTER_Z: cfg_in.center_z   = csr.data;
            CSR_COEFF:    cfg_in.coeff_main = csr.data;
            CSR_SINE:     cfg_in.coeff_sine = csr.data[SINE_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= MODE_TRANSLATE;
         cfg_ff.axis       <= AXIS_NONE;
         cfg_ff.center_x   <= '0;
         cfg_ff.center_y   <= '0;
         cfg_ff.center_z   <= '0;
         cfg_ff.coeff_main <= COORD_W'(1) << FRAC_BITS;
         cfg_ff.coeff_sine <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/avt_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex transform datapath
// Products of the centre offsets with cosine and sine, floored to the
// fixed-point grid, then selected, summed and saturated per lane.
// ----------------------------------------------------------------------------
module avt_core #(
   parameter int FRAC_BITS = avt_pkg::AVT_FRAC_BITS
) (
   input  wire avt_pkg::cfg_type                       cfg,
   input  wire logic signed [avt_pkg::COORD_W-1:0]     vtx    [avt_pkg::NUM_AXES],
   input  wire logic signed [avt_pkg::OFFSET_W-1:0]    offset [avt_pkg::NUM_AXES],
   output logic signed [avt_pkg::COORD_W-1:0]          result [avt_pkg::NUM_AXES]
);
   import avt_pkg::*;

   localparam int PROD_K_W = OFFSET_W + COORD_W;
   localparam int PROD_S_W = OFFSET_W + SINE_W;

   logic signed [PROD_K_W-1:0] prod_k [NUM_AXES];
   logic signed [PROD_S_W-1:0] prod_s [NUM_AXES];
   logic signed [SUM_W-1:0]    pk     [NUM_AXES];
   logic signed [SUM_W-1:0]    ps     [NUM_AXES];
   logic signed [SUM_W-1:0]    ctr    [NUM_AXES];
   logic signed [SUM_W-1:0]    wide   [NUM_AXES];

   // Arithmetic shift right gives the floor of the scaled product.
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         prod_k[i] = PROD_K_W'(offset[i]) * PROD_K_W'(cfg.coeff_main);
         prod_s[i] = PROD_S_W'(offset[i]) * PROD_S_W'(cfg.coeff_sine);
         pk[i]     = SUM_W'(prod_k[i] >>> FRAC_BITS);
         ps[i]     = SUM_W'(prod_s[i] >>> FRAC_BITS);
      end
   end

   assign ctr[0] = SUM_W'(cfg.center_x);
   assign ctr[1] = SUM_W'(cfg.center_y);
   assign ctr[2] = SUM_W'(cfg.center_z);

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         wide[i] = SUM_W'(vtx[i]);
      end
      case (cfg.mode)
         MODE_TRANSLATE: begin
            for (int i = 0; i < NUM_AXES; i++) begin
               if (cfg.axis == LANE_AXIS[i]) begin
                  wide[i] = SUM_W'(vtx[i]) + SUM_W'(cfg.coeff_main);
               end
            end
         end
         MODE_SCALE: begin
            for (int i = 0; i < NUM_AXES; i++) begin
               if (cfg.axis == AXIS_NONE || cfg.axis == LANE_AXIS[i]) begin
                  wide[i] = ctr[i] + pk[i];
               end
            end
         end
         MODE_ROTATE: begin
            case (cfg.axis)
               AXIS_X: begin
                  wide[1] = ctr[1] + (pk[1] - ps[2]);
                  wide[2] = ctr[2] + (ps[1] + pk[2]);
               end
               AXIS_Y: begin
                  wide[0] = ctr[0] + (pk[0] + ps[2]);
                  wide[2] = ctr[2] + (pk[2] - ps[0]);
               end
               AXIS_Z: begin
                  wide[0] = ctr[0] + (pk[0] - ps[1]);
                  wide[1] = ctr[1] + (ps[0] + pk[1]);
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      for (int i = 0; i < NUM_AXES; i++) begin
         result[i] = sat_coord(wide[i]);
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/axis_vertex_transform.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Axis-aligned vertex transform
// Translates, scales or rotates a stream of signed fixed-point vertices
// about a programmable centre, one vertex per clock while not stalled.
// ----------------------------------------------------------------------------
// The block takes one vertex per clock unless its input stalls, and passes
// each transformed vertex through two registers: the first holds the
// vertex and its offsets from the centre, the second holds the saturated
// result. Throughput is one vertex every cycle while results are taken, set
// by the single compute stage in which six offset products (three by the
// main coefficient, three by the sine) are formed in parallel. The result
// register frees the input side, so a new vertex is taken even while a
// finished result waits; only when both registers are full and the result
// is not taken does the input stall. Registers must be written only while no vertex is in flight.
// ----------------------------------------------------------------------------
module axis_vertex_transform #(
   parameter int FRAC_BITS = avt_pkg::AVT_FRAC_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   avt_req_if.sink   req_if,
   avt_rsp_if.source rsp_if,
   avt_csr_if.sink   csr_if
);
   import avt_pkg::*;

   cfg_type cfg;

   // First register: vertex and centre offsets.
   logic                       stage_valid_ff;
   logic                       stage_valid_in;
   logic signed [COORD_W-1:0]  stage_v_ff  [NUM_AXES];
   logic signed [OFFSET_W-1:0] stage_r_ff  [NUM_AXES];
   logic signed [COORD_W-1:0]  req_v       [NUM_AXES];
   logic signed [COORD_W-1:0]  req_c       [NUM_AXES];

   // Second register: transformed vertex.
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic signed [COORD_W-1:0]  res_ff      [NUM_AXES];
   logic signed [COORD_W-1:0]  res_in      [NUM_AXES];

   logic rsp_load;
   logic stage_adv;
   logic req_take;

   avt_regs #(
      .FRAC_BITS (FRAC_BITS)
   ) u_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_if),
      .cfg   (cfg)
   );

   avt_core #(
      .FRAC_BITS (FRAC_BITS)
   ) u_core (
      .cfg    (cfg),
      .vtx    (stage_v_ff),
      .offset (stage_r_ff),
      .result (res_in)
   );

   // The result register may load whenever it is empty or being drained,
   // and the first register may load whenever it is empty or its vertex moves on.
   assign rsp_load  = !rsp_valid_ff || rsp_if.ready;
   assign stage_adv = stage_valid_ff && rsp_load;
   assign req_if.ready = !stage_valid_ff || rsp_load;
   assign req_take  = req_if.valid && req_if.ready;

   assign stage_valid_in = req_if.ready ? req_if.valid : stage_valid_ff;
   assign rsp_valid_in   = rsp_load ? stage_valid_ff : rsp_valid_ff;

   assign req_v[0] = req_if.in_x;
   assign req_v[1] = req_if.in_y;
   assign req_v[2] = req_if.in_z;
   assign req_c[0] = cfg.center_x;
   assign req_c[1] = cfg.center_y;
   assign req_c[2] = cfg.center_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Offsets are exact 33-bit differences, taken as the vertex arrives.
   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            stage_v_ff[i] <= req_v[i];
            stage_r_ff[i] <= OFFSET_W'(req_v[i]) - OFFSET_W'(req_c[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            res_ff[i] <= res_in[i];
         end
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.out_x = res_ff[0];
   assign rsp_if.out_y = res_ff[1];
   assign rsp_if.out_z = res_ff[2];

   // A vertex in the first register stays there until the result register
   // can take it.
   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !rsp_load) |=> stage_valid_ff)
      else $error("vertex dropped from the first register while stalled");

   // A vertex that moves on always shows up as a valid result.
   a_stage_to_rsp: assert property (@(posedge clock) disable iff (reset)
      stage_adv |=> rsp_valid_ff)
      else $error("advanced vertex did not reach the result register");

   // A new vertex is only taken when the first register is free to load.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (!stage_valid_ff || stage_adv))
      else $error("vertex accepted over one still waiting");

   // With no axis chosen, translate passes the vertex through unchanged.
   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      (stage_adv && cfg.mode == MODE_TRANSLATE && cfg.axis == AXIS_NONE)
      |=> (rsp_if.out_x == $past(stage_v_ff[0]) && rsp_if.out_y == $past(stage_v_ff[1])
           && rsp_if.out_z == $past(stage_v_ff[2])))
      else $error("pass-through vertex was altered");

endmodule
`default_nettype wire
